// ----- sv/tctu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tctu_pkg;

	localparam int TABLE_ENTRIES = 201;
	localparam int SEGMENT_COUNT = 8;
	localparam int AUX_CHANNELS  = 9;
	localparam int RES_DATA_LEN  = 201;
	localparam int IDX_W         = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;

	localparam logic [3:0]  REF_CHANNEL    = 4'd5;
	localparam logic [15:0] FULL_SCALE     = 16'd30000;
	localparam logic [16:0] BIAS_TENTHS    = 17'd100000;

	// thermistor resistance, 0 C to 100 C in half degree steps, 0.1 ohm units
	localparam logic [18:0] RES_TENTHS [RES_DATA_LEN] = '{
		19'd292398, 19'd285716, 19'd279207, 19'd272866, 19'd266688, 19'd260669, 19'd254803,
		19'd249088, 19'd243518, 19'd238089, 19'd232798, 19'd227640, 19'd222612, 19'd217710,
		19'd212930, 19'd208270, 19'd203725, 19'd199294, 19'd194972, 19'd190756, 19'd186644,
		19'd182633, 19'd178720, 19'd174903, 19'd171178, 19'd167543, 19'd163997, 19'd160536,
		19'd157158, 19'd153861, 19'd150643, 19'd147501, 19'd144434, 19'd141440, 19'd138517,
		19'd135663, 19'd132875, 19'd130153, 19'd127495, 19'd124899, 19'd122363, 19'd119886,
		19'd117466, 19'd115102, 19'd112792, 19'd110535, 19'd108330, 19'd106175, 19'd104070,
		19'd102012, 19'd100000, 19'd98034, 19'd96112, 19'd94233, 19'd92397, 19'd90601,
		19'd88845, 19'd87129, 19'd85450, 19'd83808, 19'd82203, 19'd80633, 19'd79097,
		19'd77594, 19'd76125, 19'd74687, 19'd73281, 19'd71905, 19'd70558, 19'd69241,
		19'd67952, 19'd66690, 19'd65455, 19'd64247, 19'd63064, 19'd61907, 19'd60773,
		19'd59664, 19'd58578, 19'd57514, 19'd56473, 19'd55454, 19'd54455, 19'd53478,
		19'd52521, 19'd51583, 19'd50665, 19'd49765, 19'd48884, 19'd48021, 19'd47175,
		19'd46347, 19'd45535, 19'd44740, 19'd43961, 19'd43198, 19'd42449, 19'd41716,
		19'd40998, 19'd40293, 19'd39603, 19'd38926, 19'd38263, 19'd37613, 19'd36975,
		19'd36350, 19'd35738, 19'd35137, 19'd34548, 19'd33970, 19'd33404, 19'd32848,
		19'd32303, 19'd31769, 19'd31245, 19'd30731, 19'd30227, 19'd29732, 19'd29247,
		19'd28770, 19'd28303, 19'd27845, 19'd27395, 19'd26954, 19'd26521, 19'd26096,
		19'd25679, 19'd25269, 19'd24868, 19'd24474, 19'd24086, 19'd23706, 19'd23334,
		19'd22967, 19'd22608, 19'd22255, 19'd21909, 19'd21568, 19'd21234, 19'd20906,
		19'd20584, 19'd20268, 19'd19957, 19'd19652, 19'd19352, 19'd19058, 19'd18769,
		19'd18485, 19'd18206, 19'd17932, 19'd17662, 19'd17398, 19'd17138, 19'd16882,
		19'd16631, 19'd16385, 19'd16142, 19'd15904, 19'd15670, 19'd15440, 19'd15214,
		19'd14992, 19'd14773, 19'd14559, 19'd14348, 19'd14140, 19'd13936, 19'd13736,
		19'd13539, 19'd13345, 19'd13154, 19'd12967, 19'd12783, 19'd12602, 19'd12423,
		19'd12248, 19'd12076, 19'd11906, 19'd11740, 19'd11576, 19'd11414, 19'd11256,
		19'd11100, 19'd10946, 19'd10795, 19'd10647, 19'd10501, 19'd10357, 19'd10215,
		19'd10076, 19'd9939, 19'd9804, 19'd9672, 19'd9541, 19'd9413, 19'd9286,
		19'd9162, 19'd9039, 19'd8919, 19'd8800, 19'd8684
	};

	typedef logic [15:0] rom_t [TABLE_ENTRIES];

	// elaboration only: shift and subtract, rounded up; quotient must fit 16 bits
	function automatic logic [15:0] div_ceil16(logic [63:0] num, logic [63:0] den);
		logic [63:0] rem;
		logic [15:0] q;
		rem = num;
		q   = '0;
		for (int b = 15; b >= 0; b--) begin
			if (rem >= (den << b)) begin
				rem  = rem - (den << b);
				q[b] = 1'b1;
			end
		end
		if (rem != 64'd0)
			q = q + 16'd1;
		return q;
	endfunction

	// elaboration only: ceil(30000*L/(100000+L)) per entry, last datum repeated
	function automatic rom_t build_thresholds();
		rom_t        t;
		logic [63:0] r;
		logic [63:0] num;
		logic [63:0] den;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			r   = 64'(RES_TENTHS[(i < RES_DATA_LEN) ? i : RES_DATA_LEN - 1]);
			num = 64'(FULL_SCALE) * r;
			den = 64'(BIAS_TENTHS) + r;
			t[i] = div_ceil16(num, den);
		end
		return t;
	endfunction

	localparam rom_t THRESHOLD_ROM = build_thresholds();

	localparam logic [15:0] UPPER_CODE = 16'((64'(FULL_SCALE) * 64'(RES_TENTHS[0]))
		/ (64'(BIAS_TENTHS) + 64'(RES_TENTHS[0])));

	typedef enum logic [1:0] {
		KIND_TEMP       = 2'd0,
		KIND_VREF       = 2'd1,
		KIND_GROUP_FAIL = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_SEARCH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic drop;
		logic direct;
		logic search_done;
	} dp_status_t;

endpackage

`default_nettype wire

// ----- sv/tctu_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tctu_ctrl import tctu_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd,
	output logic            busy,
	output logic            done
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CLASSIFY;
				end
			end
			ST_CLASSIFY: begin
				if (status.drop) begin
					state_d = ST_IDLE;
				end else if (status.direct) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (status.search_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_CLASSIFY: begin
				cmd.finish = !status.drop && status.direct;
			end
			ST_SEARCH: begin
				cmd.step   = !status.search_done;
				cmd.finish = status.search_done;
			end
			ST_DONE: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted transaction did not make the unit busy");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.finish))
		else $error("result strobe without a finished transaction");

endmodule

`default_nettype wire

// ----- sv/tctu_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tctu_dp import tctu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dp_cmd_t     cmd,
	input  wire logic [15:0] raw_code,
	input  wire logic [2:0]  segment,
	input  wire logic [3:0]  aux_channel,
	input  wire logic        group_ok,
	output dp_status_t       status,
	output logic [1:0]       kind,
	output logic [2:0]       segment_out,
	output logic [2:0]       slot,
	output logic [7:0]       temp_half_deg,
	output logic             out_of_range,
	output logic [15:0]      vref_code
);

	logic [15:0]      code_q;
	logic [2:0]       seg_q;
	logic [3:0]       chan_q;
	logic             ok_q;
	logic [IDX_W-1:0] lo_q;
	logic [IDX_W-1:0] hi_q;

	logic [1:0]       kind_q;
	logic [2:0]       seg_out_q;
	logic [2:0]       slot_q;
	logic [7:0]       temp_q;
	logic             oor_q;
	logic [15:0]      vref_q;

	logic             is_ref;
	logic             oor;
	logic [2:0]       slot_c;
	logic [IDX_W:0]   mid_sum;
	logic [IDX_W-1:0] mid;
	logic             reached;

	always_comb begin
		is_ref = (chan_q == REF_CHANNEL);
		oor = (code_q >= FULL_SCALE) || (code_q > UPPER_CODE)
			|| (code_q < THRESHOLD_ROM[TABLE_ENTRIES - 1]);
		slot_c = (chan_q > REF_CHANNEL) ? 3'(chan_q - 4'd1) : 3'(chan_q);
		status.drop = (32'(chan_q) >= AUX_CHANNELS) || (32'(seg_q) >= SEGMENT_COUNT);
		status.direct = !ok_q || is_ref || oor;
		status.search_done = (lo_q == hi_q);
		mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
		mid = mid_sum[IDX_W:1];
		reached = (code_q >= THRESHOLD_ROM[mid]);
	end

	// binary search for the first threshold the code reaches
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			code_q <= raw_code;
			seg_q  <= segment;
			chan_q <= aux_channel;
			ok_q   <= group_ok;
			lo_q   <= '0;
			hi_q   <= IDX_W'(TABLE_ENTRIES - 1);
		end else if (cmd.step) begin
			if (reached) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			seg_out_q <= seg_q;
			kind_q    <= KIND_TEMP;
			slot_q    <= '0;
			temp_q    <= '0;
			oor_q     <= 1'b0;
			vref_q    <= '0;
			if (!ok_q) begin
				kind_q <= KIND_GROUP_FAIL;
			end else if (is_ref) begin
				kind_q <= KIND_VREF;
				vref_q <= code_q;
			end else begin
				slot_q <= slot_c;
				if (oor) begin
					oor_q <= 1'b1;
				end else begin
					temp_q <= 8'(lo_q);
				end
			end
		end
	end

	assign kind          = kind_q;
	assign segment_out   = seg_out_q;
	assign slot          = slot_q;
	assign temp_half_deg = temp_q;
	assign out_of_range  = oor_q;
	assign vref_code     = vref_q;

	a_step_open_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> lo_q < hi_q)
		else $error("search step on a closed interval");

	a_step_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> hi_q <= IDX_W'(TABLE_ENTRIES - 1))
		else $error("search bound past the end of the table");

endmodule

`default_nettype wire

// ----- sv/thermistor_code_to_temperature_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel  | handshake          | fields
// ---------+--------------------+--------------------------------------------------
// request  | start, busy        | raw_code, segment, aux_channel, group_ok
// result   | done (one cycle)   | kind, segment_out, slot, temp_half_deg,
//          |                    | out_of_range, vref_code
//
// a transaction is taken when start is high and busy is low
// direct results (group failed, reference, out of range) go from classify straight to done
// a table lookup binary-searches the threshold rom, one compare per cycle:
// 7 or 8 steps for 201 entries
// done is a single-cycle strobe; the receiver cannot hold it, busy drops the cycle after
// items on a channel or segment past the configured count return no result
// arst_n clears the controller; the rom is constant logic and needs no fill

module thermistor_code_to_temperature_unit import tctu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] raw_code,
	input  wire logic [2:0]  segment,
	input  wire logic [3:0]  aux_channel,
	input  wire logic        group_ok,
	output logic             done,
	output logic [1:0]       kind,
	output logic [2:0]       segment_out,
	output logic [2:0]       slot,
	output logic [7:0]       temp_half_deg,
	output logic             out_of_range,
	output logic [15:0]      vref_code
);

	dp_cmd_t    cmd;
	dp_status_t status;

	tctu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	tctu_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.raw_code      (raw_code),
		.segment       (segment),
		.aux_channel   (aux_channel),
		.group_ok      (group_ok),
		.status        (status),
		.kind          (kind),
		.segment_out   (segment_out),
		.slot          (slot),
		.temp_half_deg (temp_half_deg),
		.out_of_range  (out_of_range),
		.vref_code     (vref_code)
	);

endmodule

`default_nettype wire

// ----- dv/thermistor_code_to_temperature_unit_tb.sv -----
`timescale 1ns / 1ps

import tctu_pkg::*;

typedef struct packed {
	kind_t       kind;
	logic [2:0]  segment;
	logic [2:0]  slot;
	logic [7:0]  temp;
	logic        oor;
	logic [15:0] vref;
} conversion_t;

class conversion_tracker;
	localparam int RES_POINTS = 201;

	// ntc resistance, 0 C to 100 C in half degree steps, 0.1 ohm units
	int unsigned ntc_tenths [RES_POINTS] = '{
		292398, 285716, 279207, 272866, 266688, 260669, 254803, 249088, 243518, 238089, 232798,
		227640, 222612, 217710, 212930, 208270, 203725, 199294, 194972, 190756, 186644, 182633,
		178720, 174903, 171178, 167543, 163997, 160536, 157158, 153861, 150643, 147501, 144434,
		141440, 138517, 135663, 132875, 130153, 127495, 124899, 122363, 119886, 117466, 115102,
		112792, 110535, 108330, 106175, 104070, 102012, 100000, 98034, 96112, 94233, 92397,
		90601, 88845, 87129, 85450, 83808, 82203, 80633, 79097, 77594, 76125, 74687,
		73281, 71905, 70558, 69241, 67952, 66690, 65455, 64247, 63064, 61907, 60773,
		59664, 58578, 57514, 56473, 55454, 54455, 53478, 52521, 51583, 50665, 49765,
		48884, 48021, 47175, 46347, 45535, 44740, 43961, 43198, 42449, 41716, 40998,
		40293, 39603, 38926, 38263, 37613, 36975, 36350, 35738, 35137, 34548, 33970,
		33404, 32848, 32303, 31769, 31245, 30731, 30227, 29732, 29247, 28770, 28303,
		27845, 27395, 26954, 26521, 26096, 25679, 25269, 24868, 24474, 24086, 23706,
		23334, 22967, 22608, 22255, 21909, 21568, 21234, 20906, 20584, 20268, 19957,
		19652, 19352, 19058, 18769, 18485, 18206, 17932, 17662, 17398, 17138, 16882,
		16631, 16385, 16142, 15904, 15670, 15440, 15214, 14992, 14773, 14559, 14348,
		14140, 13936, 13736, 13539, 13345, 13154, 12967, 12783, 12602, 12423, 12248,
		12076, 11906, 11740, 11576, 11414, 11256, 11100, 10946, 10795, 10647, 10501,
		10357, 10215, 10076, 9939, 9804, 9672, 9541, 9413, 9286, 9162, 9039,
		8919, 8800, 8684
	};

	logic [15:0] thr_code [TABLE_ENTRIES];
	logic [15:0] top_code;
	conversion_t pending_conversions [$];
	int          errors;

	function new();
		longint unsigned r;
		longint unsigned num;
		longint unsigned den;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			// entries past the resistance data repeat the last point
			r   = ntc_tenths[(i < RES_POINTS) ? i : RES_POINTS - 1];
			num = 64'd30000 * r;
			den = 64'd100000 + r;
			thr_code[i] = 16'((num + den - 64'd1) / den);
		end
		r        = ntc_tenths[0];
		top_code = 16'((64'd30000 * r) / (64'd100000 + r));
		errors   = 0;
	endfunction

	function int outstanding();
		return pending_conversions.size();
	endfunction

	function void note_reading(logic [15:0] code, logic [2:0] seg, logic [3:0] chan, logic ok);
		conversion_t c;
		int          idx;
		if (chan >= AUX_CHANNELS || seg >= SEGMENT_COUNT)
			return;
		c         = '0;
		c.segment = seg;
		if (!ok) begin
			c.kind = KIND_GROUP_FAIL;
		end else if (chan == REF_CHANNEL) begin
			c.kind = KIND_VREF;
			c.vref = code;
		end else begin
			c.kind = KIND_TEMP;
			c.slot = (chan > REF_CHANNEL) ? 3'(chan - 4'd1) : chan[2:0];
			if (code >= 16'd30000 || code > top_code || code < thr_code[TABLE_ENTRIES - 1]) begin
				c.oor = 1'b1;
			end else begin
				idx = 0;
				while (idx < TABLE_ENTRIES - 1 && code < thr_code[idx])
					idx++;
				c.temp = 8'(idx);
			end
		end
		pending_conversions.push_back(c);
	endfunction

	task report_mismatch(string msg);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task check_conversion(logic [1:0] k, logic [2:0] seg, logic [2:0] sl, logic [7:0] t,
		logic oor, logic [15:0] vref);
		conversion_t e;
		if (pending_conversions.size() == 0) begin
			report_mismatch("result with no reading outstanding");
			return;
		end
		e = pending_conversions.pop_front();
		if (k !== e.kind)
			report_mismatch($sformatf("kind %0d, want %0d", k, e.kind));
		if (seg !== e.segment)
			report_mismatch($sformatf("segment_out %0d, want %0d", seg, e.segment));
		if (sl !== e.slot)
			report_mismatch($sformatf("slot %0d, want %0d", sl, e.slot));
		if (t !== e.temp)
			report_mismatch($sformatf("temp_half_deg %0d, want %0d", t, e.temp));
		if (oor !== e.oor)
			report_mismatch($sformatf("out_of_range %0b, want %0b", oor, e.oor));
		if (vref !== e.vref)
			report_mismatch($sformatf("vref_code %0d, want %0d", vref, e.vref));
	endtask
endclass

module thermistor_code_to_temperature_unit_tb;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int DRAIN_CYCLES    = 24;
	localparam int ITEMS_PER_PHASE = 134;
	localparam int PHASES          = 3;
	localparam int PHASE_IDLE [PHASES] = '{0, 64, 7};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] raw_code;
	logic [2:0]  segment;
	logic [3:0]  aux_channel;
	logic        group_ok;
	logic        done;
	logic [1:0]  kind;
	logic [2:0]  segment_out;
	logic [2:0]  slot;
	logic [7:0]  temp_half_deg;
	logic        out_of_range;
	logic [15:0] vref_code;

	conversion_tracker tracker;
	int                cycle_count = 0;

	thermistor_code_to_temperature_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.raw_code(raw_code),
		.segment(segment),
		.aux_channel(aux_channel),
		.group_ok(group_ok),
		.done(done),
		.kind(kind),
		.segment_out(segment_out),
		.slot(slot),
		.temp_half_deg(temp_half_deg),
		.out_of_range(out_of_range),
		.vref_code(vref_code)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("thermistor_code_to_temperature_unit_tb: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			tracker.check_conversion(kind, segment_out, slot, temp_half_deg, out_of_range,
				vref_code);
	end

	// holds the reading on the ports until the transaction is taken
	task automatic send_reading(logic [15:0] code, logic [2:0] seg, logic [3:0] chan, logic ok);
		start       <= 1'b1;
		raw_code    <= code;
		segment     <= seg;
		aux_channel <= chan;
		group_ok    <= ok;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		tracker.note_reading(code, seg, chan, ok);
	endtask

	task automatic pause_sender(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	initial begin
		int          idle_pct;
		int          sent;
		int unsigned pick;
		int unsigned k;
		logic [15:0] code;
		logic [2:0]  seg;
		logic [3:0]  chan;
		logic        ok;

		tracker     = new();
		arst_n      <= 1'b0;
		start       <= 1'b0;
		raw_code    <= '0;
		segment     <= '0;
		aux_channel <= '0;
		group_ok    <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reference pass-through and failed groups
		send_reading(16'd0, 3'd0, REF_CHANNEL, 1'b1);
		send_reading(16'hFFFF, 3'd7, REF_CHANNEL, 1'b1);
		send_reading(16'hFFFF, 3'd7, REF_CHANNEL, 1'b0);
		send_reading(16'd12345, 3'd3, 4'd0, 1'b0);
		send_reading(16'd0, 3'd5, 4'd8, 1'b0);
		// channels past the last one produce nothing
		send_reading(16'd15000, 3'd1, 4'd9, 1'b1);
		send_reading(16'hFFFF, 3'd7, 4'd15, 1'b0);
		// table edges and the divider saturating at full scale
		send_reading(16'd0, 3'd2, 4'd0, 1'b1);
		send_reading(16'hFFFF, 3'd4, 4'd4, 1'b1);
		send_reading(16'd30000, 3'd6, 4'd6, 1'b1);
		send_reading(16'd29999, 3'd7, 4'd8, 1'b1);
		send_reading(16'h8000, 3'd0, 4'd2, 1'b1);
		send_reading(tracker.top_code, 3'd1, 4'd1, 1'b1);
		send_reading(tracker.top_code + 16'd1, 3'd2, 4'd2, 1'b1);
		send_reading(tracker.thr_code[0], 3'd3, 4'd3, 1'b1);
		send_reading(tracker.thr_code[0] - 16'd1, 3'd4, 4'd7, 1'b1);
		send_reading(tracker.thr_code[1], 3'd5, 4'd4, 1'b1);
		send_reading(tracker.thr_code[TABLE_ENTRIES - 1], 3'd6, 4'd0, 1'b1);
		send_reading(tracker.thr_code[TABLE_ENTRIES - 1] - 16'd1, 3'd7, 4'd8, 1'b1);
		send_reading(tracker.thr_code[100], 3'd0, 4'd6, 1'b1);
		send_reading(tracker.thr_code[100] - 16'd1, 3'd1, 4'd6, 1'b1);

		for (int ph = 0; ph < PHASES; ph++) begin
			idle_pct = PHASE_IDLE[ph];
			sent     = 0;
			while (sent < ITEMS_PER_PHASE) begin
				pick = $urandom_range(99);
				seg  = 3'($urandom_range(7));
				k    = $urandom_range(7);
				chan = (k >= REF_CHANNEL) ? 4'(k + 1) : 4'(k);
				ok   = 1'b1;
				if (pick < 55) begin
					// straddle a random threshold
					k    = $urandom_range(TABLE_ENTRIES - 1);
					code = tracker.thr_code[k] + 16'($urandom_range(2)) - 16'd1;
				end else if (pick < 65) begin
					code = 16'($urandom_range(tracker.top_code,
						tracker.thr_code[TABLE_ENTRIES - 1]));
				end else if (pick < 73) begin
					chan = REF_CHANNEL;
					code = 16'($urandom);
				end else if (pick < 81) begin
					chan = 4'($urandom_range(AUX_CHANNELS - 1));
					ok   = 1'b0;
					code = 16'($urandom);
				end else if (pick < 89) begin
					chan = 4'($urandom_range(AUX_CHANNELS - 1));
					ok   = 1'($urandom_range(1));
					code = 16'($urandom);
				end else if (pick < 95) begin
					code = 16'($urandom_range(65535, 29990));
				end else begin
					chan = 4'($urandom_range(15, AUX_CHANNELS));
					ok   = 1'($urandom_range(1));
					code = 16'($urandom);
				end
				send_reading(code, seg, chan, ok);
				if (chan < AUX_CHANNELS)
					sent++;
				if ($urandom_range(99) < idle_pct)
					pause_sender($urandom_range(15, 1));
			end
		end

		start <= 1'b0;
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("thermistor_code_to_temperature_unit_tb: done, clean");
		else
			$display("thermistor_code_to_temperature_unit_tb: done, errors");
		$finish;
	end
endmodule
